// File: hw/rtl/ctb_pkg.sv
// Shared constants, permutation tables and types of the columnar transposition block.
package ctb_pkg;

  localparam int BlockLen  = 25;
  localparam int IdxW      = 5;
  localparam int TailLen   = 6;
  localparam int RamDepth  = 2 * BlockLen;
  localparam int RamAddrW  = $clog2(RamDepth);
  localparam int DescDepth = 2;
  localparam int OutDepth  = 4;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(BlockLen - 1);

  localparam logic [7:0] PadMark   = 8'h2A;
  localparam logic [7:0] SpaceByte = 8'h20;

  // Configuration register indexes.
  localparam logic CfgDirection = 1'b0;
  localparam logic CfgKeySet    = 1'b1;

  localparam logic DirEncrypt = 1'b0;
  localparam logic DirDecrypt = 1'b1;
  localparam logic KeyFirst   = 1'b0;
  localparam logic KeySecond  = 1'b1;

  localparam logic [7:0] TailLetters [TailLen] = '{
    8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61
  };

  // Pad byte by distance from the first free byte; distance zero is the pad mark.
  localparam logic [7:0] PadByte [BlockLen] = '{
    8'h2A, 8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h66, 8'h63, 8'h64,
    8'h62, 8'h66, 8'h61, 8'h66, 8'h65, 8'h62, 8'h63, 8'h66, 8'h61, 8'h66,
    8'h62, 8'h64, 8'h65, 8'h66, 8'h61
  };

  // Ciphertext position to block byte index, per key.
  localparam logic [IdxW-1:0] GridIdx [2][BlockLen] = '{
    '{5'd2, 5'd8, 5'd14, 5'd20, 5'd5, 5'd11, 5'd17, 5'd23, 5'd4, 5'd10,
      5'd16, 5'd22, 5'd1, 5'd7, 5'd13, 5'd19, 5'd3, 5'd9, 5'd15, 5'd21,
      5'd0, 5'd6, 5'd12, 5'd18, 5'd24},
    '{5'd1, 5'd7, 5'd13, 5'd19, 5'd3, 5'd9, 5'd15, 5'd21, 5'd0, 5'd6,
      5'd12, 5'd18, 5'd5, 5'd11, 5'd17, 5'd23, 5'd2, 5'd8, 5'd14, 5'd20,
      5'd4, 5'd10, 5'd16, 5'd22, 5'd24}
  };

  // Plaintext position to block byte index, per key.
  localparam logic [IdxW-1:0] InvIdx [2][BlockLen] = '{
    '{5'd20, 5'd12, 5'd0, 5'd16, 5'd8, 5'd4, 5'd21, 5'd13, 5'd1, 5'd17,
      5'd9, 5'd5, 5'd22, 5'd14, 5'd2, 5'd18, 5'd10, 5'd6, 5'd23, 5'd15,
      5'd3, 5'd19, 5'd11, 5'd7, 5'd24},
    '{5'd8, 5'd0, 5'd16, 5'd4, 5'd20, 5'd12, 5'd9, 5'd1, 5'd17, 5'd5,
      5'd21, 5'd13, 5'd10, 5'd2, 5'd18, 5'd6, 5'd22, 5'd14, 5'd11, 5'd3,
      5'd19, 5'd7, 5'd23, 5'd15, 5'd24}
  };

  typedef struct packed {
    logic            bank;
    logic [IdxW-1:0] count;
    logic            last;
  } ctb_desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } ctb_done_t;

  typedef struct packed {
    logic direction;
    logic key_set;
  } ctb_cfg_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       has_symbol;
    logic       eom;
  } ctb_res_t;

  function automatic logic [RamAddrW-1:0] ram_addr(input logic bank,
                                                   input logic [IdxW-1:0] idx);
    logic [RamAddrW-1:0] base;
    base = bank ? RamAddrW'(BlockLen) : '0;
    return RamAddrW'(idx) + base;
  endfunction

endpackage

// File: hw/rtl/ctb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ctb_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ctb_front.sv
// Intake side: writes message bytes into one of two block banks and closes blocks.
module ctb_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     symbol_i,
  input  logic                           final_req_i,
  output logic                           ram_we_o,
  output logic [ctb_pkg::RamAddrW-1:0]   ram_waddr_o,
  output logic [7:0]                     ram_wdata_o,
  output logic                           desc_push_o,
  output ctb_pkg::ctb_desc_t             desc_o,
  input  ctb_pkg::ctb_done_t             done_i
);

  logic                      wr_bank_q, wr_bank_d;
  logic [ctb_pkg::IdxW-1:0]  fill_q, fill_d;
  logic [1:0]                busy_q, busy_d;
  logic [ctb_pkg::IdxW-1:0]  fill_inc;
  logic                      accept;
  logic                      close;

  // A bank stays busy from the close of its block until the back end has read it out.
  assign full        = busy_q[wr_bank_q];
  assign accept      = push & ~full;
  assign fill_inc    = fill_q + ctb_pkg::IdxW'(1);
  assign close       = accept & ((fill_inc == ctb_pkg::IdxW'(ctb_pkg::BlockLen)) | final_req_i);

  assign ram_we_o    = accept;
  assign ram_waddr_o = ctb_pkg::ram_addr(wr_bank_q, fill_q);
  assign ram_wdata_o = symbol_i;

  assign desc_push_o = close;
  assign desc_o      = '{bank: wr_bank_q, count: fill_inc, last: final_req_i};

  always_comb begin
    wr_bank_d = wr_bank_q;
    fill_d    = fill_q;
    busy_d    = busy_q;
    if (done_i.valid) begin
      busy_d[done_i.bank] = 1'b0;
    end
    if (close) begin
      busy_d[wr_bank_q] = 1'b1;
      wr_bank_d         = ~wr_bank_q;
      fill_d            = '0;
    end else if (accept) begin
      fill_d = fill_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_bank_q <= 1'b0;
      fill_q    <= '0;
      busy_q    <= '0;
    end else begin
      wr_bank_q <= wr_bank_d;
      fill_q    <= fill_d;
      busy_q    <= busy_d;
    end
  end

endmodule

// File: hw/rtl/ctb_desc_fifo.sv
// Short queue of closed-block descriptors between the intake and the back end.
module ctb_desc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ctb_pkg::ctb_desc_t desc_i,
  input  logic               pop_i,
  output logic               empty_o,
  output ctb_pkg::ctb_desc_t desc_o
);

  localparam int PtrW = $clog2(ctb_pkg::DescDepth);
  localparam int CntW = $clog2(ctb_pkg::DescDepth + 1);

  ctb_pkg::ctb_desc_t entry_q [ctb_pkg::DescDepth];
  logic [PtrW-1:0]    wptr_q, wptr_d;
  logic [PtrW-1:0]    rptr_q, rptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_pop;

  assign empty_o = (cnt_q == '0);
  assign desc_o  = entry_q[rptr_q];
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = rptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= desc_i;
    end
  end

endmodule

// File: hw/rtl/ctb_back.sv
// Back end: reads a closed block out in permuted order, strips padding and queues results.
module ctb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ctb_pkg::ctb_cfg_t              cfg_i,
  input  logic                           desc_empty_i,
  input  ctb_pkg::ctb_desc_t             desc_i,
  output logic                           desc_pop_o,
  output logic                           ram_re_o,
  output logic [ctb_pkg::RamAddrW-1:0]   ram_raddr_o,
  input  logic [7:0]                     ram_rdata_i,
  output ctb_pkg::ctb_done_t             done_o,
  output logic                           empty,
  input  logic                           pop,
  output ctb_pkg::ctb_res_t              res_o
);

  localparam int IdxW     = ctb_pkg::IdxW;
  localparam int OutPtrW  = $clog2(ctb_pkg::OutDepth);
  localparam int OutCntW  = $clog2(ctb_pkg::OutDepth + 1);

  typedef enum logic [3:0] {
    StIdle    = 4'b0001,
    StScan    = 4'b0010,
    StScanEnd = 4'b0100,
    StEmit    = 4'b1000
  } ctb_back_state_e;

  ctb_back_state_e      state_q, state_d;
  ctb_pkg::ctb_desc_t   desc_q, desc_d;
  logic                 dir_q, dir_d;
  logic                 ks_q, ks_d;
  logic [IdxW-1:0]      x_q, x_d;
  logic [IdxW-1:0]      len_q, len_d;
  logic [1:0]           gp_q, gp_d;
  logic                 any_q, any_d;
  logic                 sp_done_q, sp_done_d;

  // Read stage: one beat in flight between address issue and registered RAM data.
  logic                 emit_vld_q, emit_vld_d;
  logic                 scan_vld_q, scan_vld_d;
  logic [IdxW-1:0]      scan_idx_q, scan_idx_d;
  logic                 use_ram_q, use_ram_d;
  logic [7:0]           const_q, const_d;
  logic                 has_q, has_d;
  logic                 eom_q, eom_d;

  logic [7:0]           win_q [ctb_pkg::TailLen];

  ctb_pkg::ctb_res_t    ofifo_q [ctb_pkg::OutDepth];
  logic [OutPtrW-1:0]   owp_q, orp_q;
  logic [OutCntW-1:0]   ocnt_q, ocnt_d;

  logic [IdxW-1:0]      sidx;
  logic                 is_pad;
  logic [IdxW-1:0]      pad_off;
  logic [7:0]           pad_byte;
  logic                 room;
  logic                 spacing;
  logic                 finish;
  logic [7:0]           stage_byte;
  logic [IdxW-1:0]      rem;
  logic                 tail_ok;
  logic                 o_push, o_pop;

  // Block byte index of the current position: column read-out for encrypt, inverse for decrypt.
  assign sidx     = (dir_q == ctb_pkg::DirDecrypt) ? ctb_pkg::InvIdx[ks_q][x_q]
                                                   : ctb_pkg::GridIdx[ks_q][x_q];
  assign is_pad   = (sidx >= desc_q.count);
  assign pad_off  = sidx - desc_q.count;
  assign pad_byte = is_pad ? ctb_pkg::PadByte[pad_off] : 8'h00;
  assign ram_raddr_o = ctb_pkg::ram_addr(desc_q.bank, sidx);

  assign room    = (ocnt_q + OutCntW'(emit_vld_q)) < OutCntW'(ctb_pkg::OutDepth);
  assign spacing = (dir_q == ctb_pkg::DirEncrypt) && (ks_q == ctb_pkg::KeySecond);

  assign stage_byte = use_ram_q ? ram_rdata_i : const_q;

  always_comb begin
    state_d    = state_q;
    desc_d     = desc_q;
    dir_d      = dir_q;
    ks_d       = ks_q;
    x_d        = x_q;
    len_d      = len_q;
    gp_d       = gp_q;
    any_d      = any_q;
    sp_done_d  = sp_done_q;
    desc_pop_o = 1'b0;
    ram_re_o   = 1'b0;
    done_o     = '0;
    finish     = 1'b0;
    emit_vld_d = 1'b0;
    scan_vld_d = 1'b0;
    scan_idx_d = x_q;
    use_ram_d  = 1'b0;
    const_d    = 8'h00;
    has_d      = 1'b1;
    eom_d      = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (!desc_empty_i) begin
          desc_pop_o = 1'b1;
          desc_d     = desc_i;
          dir_d      = cfg_i.direction;
          ks_d       = cfg_i.key_set;
          len_d      = IdxW'(ctb_pkg::BlockLen);
          sp_done_d  = 1'b0;
          if (cfg_i.direction == ctb_pkg::DirDecrypt && desc_i.last) begin
            state_d = StScan;
            x_d     = ctb_pkg::LastIdx;
          end else begin
            state_d = StEmit;
            x_d     = '0;
          end
        end
      end
      StScan: begin
        // Walk the plaintext from the end so the pad tail is seen before its mark.
        scan_vld_d = 1'b1;
        use_ram_d  = ~is_pad;
        ram_re_o   = ~is_pad;
        const_d    = pad_byte;
        if (x_q == '0) begin
          state_d = StScanEnd;
        end else begin
          x_d = x_q - IdxW'(1);
        end
      end
      StScanEnd: begin
        x_d     = '0;
        state_d = StEmit;
      end
      StEmit: begin
        if (room) begin
          emit_vld_d = 1'b1;
          if (len_q == '0) begin
            has_d  = 1'b0;
            eom_d  = desc_q.last;
            finish = 1'b1;
          end else if (spacing && any_q && gp_q == 2'd0 && !sp_done_q) begin
            const_d   = ctb_pkg::SpaceByte;
            sp_done_d = 1'b1;
          end else begin
            use_ram_d = ~is_pad;
            ram_re_o  = ~is_pad;
            const_d   = pad_byte;
            sp_done_d = 1'b0;
            if (dir_q == ctb_pkg::DirEncrypt) begin
              gp_d  = gp_q + 2'd1;
              any_d = 1'b1;
            end
            if (x_q == len_q - IdxW'(1)) begin
              eom_d  = desc_q.last;
              finish = 1'b1;
            end else begin
              x_d = x_q + IdxW'(1);
            end
          end
          if (finish) begin
            done_o.valid = 1'b1;
            done_o.bank  = desc_q.bank;
            state_d      = StIdle;
            if (desc_q.last) begin
              gp_d  = '0;
              any_d = 1'b0;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Pad stripping: a mark followed by a prefix of the tail letters cuts the block there.
    rem     = len_q - scan_idx_q - IdxW'(1);
    tail_ok = 1'b1;
    for (int j = 0; j < ctb_pkg::TailLen; j++) begin
      if (IdxW'(j) < rem && win_q[j] != ctb_pkg::TailLetters[j]) begin
        tail_ok = 1'b0;
      end
    end
    if (scan_vld_q && scan_idx_q < len_q && stage_byte == ctb_pkg::PadMark && tail_ok) begin
      len_d = scan_idx_q;
    end
  end

  assign o_push = emit_vld_q;
  assign o_pop  = pop & ~empty;
  assign empty  = (ocnt_q == '0);
  assign res_o  = ofifo_q[orp_q];

  always_comb begin
    ocnt_d = ocnt_q;
    if (o_push && !o_pop) begin
      ocnt_d = ocnt_q + OutCntW'(1);
    end else if (!o_push && o_pop) begin
      ocnt_d = ocnt_q - OutCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      desc_q     <= '0;
      dir_q      <= ctb_pkg::DirEncrypt;
      ks_q       <= ctb_pkg::KeyFirst;
      x_q        <= '0;
      len_q      <= '0;
      gp_q       <= '0;
      any_q      <= 1'b0;
      sp_done_q  <= 1'b0;
      emit_vld_q <= 1'b0;
      scan_vld_q <= 1'b0;
      owp_q      <= '0;
      orp_q      <= '0;
      ocnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      desc_q     <= desc_d;
      dir_q      <= dir_d;
      ks_q       <= ks_d;
      x_q        <= x_d;
      len_q      <= len_d;
      gp_q       <= gp_d;
      any_q      <= any_d;
      sp_done_q  <= sp_done_d;
      emit_vld_q <= emit_vld_d;
      scan_vld_q <= scan_vld_d;
      ocnt_q     <= ocnt_d;
      if (o_push) begin
        owp_q <= owp_q + OutPtrW'(1);
      end
      if (o_pop) begin
        orp_q <= orp_q + OutPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    use_ram_q  <= use_ram_d;
    const_q    <= const_d;
    has_q      <= has_d;
    eom_q      <= eom_d;
    if (scan_vld_q) begin
      win_q[0] <= stage_byte;
      for (int j = 1; j < ctb_pkg::TailLen; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
    if (o_push) begin
      ofifo_q[owp_q] <= '{symbol: stage_byte, has_symbol: has_q, eom: eom_q};
    end
  end

endmodule

// File: hw/rtl/columnar_transposition_block.sv
// Top level: six-column transposition over 25-byte blocks, queue-style ports on both sides.
// Intake takes one byte per cycle into a two-bank block store while a bank is free.
// A closed block goes through the descriptor queue to the back end; a final decrypt block
// first runs a pad scan over all 25 positions. Results leave at one beat per cycle unless
// the output queue is full; the back end is bound by the single RAM read port.
// Reset clears control state and both registers to zero; the block store itself is not cleared.
module columnar_transposition_block (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] symbol_i,
  input  logic       final_req_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_symbol_o,
  output logic       has_symbol_o,
  output logic       end_of_message_o
);

  ctb_pkg::ctb_cfg_t   cfg_q;
  ctb_pkg::ctb_desc_t  front_desc;
  ctb_pkg::ctb_desc_t  back_desc;
  ctb_pkg::ctb_done_t  done;
  ctb_pkg::ctb_res_t   res;

  logic                          desc_push;
  logic                          desc_pop;
  logic                          desc_empty;
  logic                          ram_we;
  logic [ctb_pkg::RamAddrW-1:0]  ram_waddr;
  logic [7:0]                    ram_wdata;
  logic                          ram_re;
  logic [ctb_pkg::RamAddrW-1:0]  ram_raddr;
  logic [7:0]                    ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ctb_pkg::CfgDirection: cfg_q.direction <= cfg_wdata_i;
        ctb_pkg::CfgKeySet:    cfg_q.key_set   <= cfg_wdata_i;
        default:               cfg_q           <= cfg_q;
      endcase
    end
  end

  ctb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .symbol_i    (symbol_i),
    .final_req_i (final_req_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .desc_push_o (desc_push),
    .desc_o      (front_desc),
    .done_i      (done)
  );

  ctb_ram #(
    .Width (8),
    .Depth (ctb_pkg::RamDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ctb_desc_fifo u_desc_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .desc_i  (front_desc),
    .pop_i   (desc_pop),
    .empty_o (desc_empty),
    .desc_o  (back_desc)
  );

  ctb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .desc_empty_i (desc_empty),
    .desc_i       (back_desc),
    .desc_pop_o   (desc_pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .done_o       (done),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res)
  );

  assign out_symbol_o     = res.symbol;
  assign has_symbol_o     = res.has_symbol;
  assign end_of_message_o = res.eom;

endmodule
